// ----- hdl/ugn_pkg.sv -----
// ugn_pkg: field widths, codes and the controller/datapath command and status words
// for the uniform grid neighbor engine; no dependencies
package ugn_pkg;

    localparam int KIND_W     = 3;
    localparam int ID_W       = 16;
    localparam int POS_W      = 24;
    localparam int RAD_W      = 23;
    localparam int LIM_W      = 7;
    localparam int ST_W       = 2;
    localparam int GRID_W     = 7;
    localparam int SCALE_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_RESULTS = 64;

    // shared multiplier: 26x26 signed, 52 bit product
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CELL_SHIFT = 32;
    localparam int HI_W       = PROD_W - CELL_SHIFT;

    // distance arithmetic
    localparam int DW    = POS_W + 1;
    localparam int SQ_W  = 2 * POS_W + 1;
    localparam int SUM_W = SQ_W + 1;
    localparam int RSQ_W = 2 * RAD_W;

    localparam int ENT_W = ID_W + 2 * POS_W;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT = 3'd0,
        K_CLEAR  = 3'd1,
        K_CELL   = 3'd2,
        K_NBHD   = 3'd3,
        K_RADIUS = 3'd4
    } kind_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 3'd0,
        CFG_ROWS    = 3'd1,
        CFG_COL_SC  = 3'd2,
        CFG_ROW_SC  = 3'd3,
        CFG_SPAN_SC = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MOP_NONE = 3'd0,
        MOP_COL  = 3'd1,
        MOP_ROW  = 3'd2,
        MOP_SPAN = 3'd3,
        MOP_RSQ  = 3'd4,
        MOP_DX   = 3'd5,
        MOP_DY   = 3'd6
    } mul_op_t;

    typedef struct packed {
        logic    load_item;
        mul_op_t mul_op;
        logic    span_fixed;
        logic    scan_init;
        logic    scan_next;
        logic    fill_rd;
        logic    ent_init;
        logic    ent_rd;
        logic    ent_next;
        logic    ins_write;
        logic    set_fin;
        status_t fin_code;
        logic    hit;
        logic    out_final;
        logic    sweep_step;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic cell_ok;
        logic last_cell;
        logic ent_more;
        logic full;
        logic in_range;
        logic limit_next;
        logic pend_valid;
        logic out_free;
        logic sweep_last;
    } stat_t;

endpackage

// ----- hdl/ugn_ifs.sv -----
// ugn channel interfaces: item, result and configuration write channels
// depends on ugn_pkg
interface ugn_item_if;
    logic                             valid;
    logic                             ready;
    logic [ugn_pkg::KIND_W-1:0]       kind;
    logic [ugn_pkg::ID_W-1:0]         particle_id;
    logic signed [ugn_pkg::POS_W-1:0] pos_x;
    logic signed [ugn_pkg::POS_W-1:0] pos_y;
    logic [ugn_pkg::RAD_W-1:0]        radius;
    logic [ugn_pkg::LIM_W-1:0]        result_limit;

    modport source (output valid, kind, particle_id, pos_x, pos_y, radius, result_limit,
                    input ready);
    modport sink (input valid, kind, particle_id, pos_x, pos_y, radius, result_limit,
                  output ready);
endinterface

interface ugn_result_if;
    logic                             valid;
    logic                             ready;
    logic [ugn_pkg::ST_W-1:0]         status;
    logic [ugn_pkg::ID_W-1:0]         found_id;
    logic signed [ugn_pkg::POS_W-1:0] found_x;
    logic signed [ugn_pkg::POS_W-1:0] found_y;
    logic                             last;

    modport source (output valid, status, found_id, found_x, found_y, last, input ready);
    modport sink (input valid, status, found_id, found_x, found_y, last, output ready);
endinterface

interface ugn_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ugn_pkg::CFG_IDX_W-1:0]     index;
    logic [ugn_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/uniform_grid_neighbor_engine_top.sv -----
// uniform_grid_neighbor_engine_top: particle binning table on a uniform grid
// depends on ugn_pkg, ugn_ifs, ugn_controller and ugn_datapath
//
//   channel  dir  handshake     payload
//   items    in   valid/ready   kind, particle_id, pos_x, pos_y, radius, result_limit
//   results  out  valid/ready   status, found_id, found_x, found_y, last
//   cfg      in   valid/ready   index, data (ready held high)
//
// a query walks every window cell, reads the fill count of each cell on the grid and
// then each stored entry, with a distance test for radius queries, and returns one word
// per hit; the fill/entry memories and the one shared multiplier are used in turn
// after reset a sweep zeroes every cell fill count; items wait until it ends, config
// writes are taken throughout
// one result word is held in the output register; a stalled results channel holds
// the sequencer only when a second word is ready to go
module uniform_grid_neighbor_engine_top #(
    parameter int MAX_COLUMNS   = 64,
    parameter int MAX_ROWS      = 64,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_CELL_SPAN = 3
) (
    input logic          clk,
    input logic          rst_n,
    ugn_item_if.sink     items,
    ugn_result_if.source results,
    ugn_cfg_if.sink      cfg
);

    // command and status words between sequencer and datapath
    ugn_pkg::cmd_t  cmd;
    ugn_pkg::stat_t stat;
    logic           in_ready;

    assign items.ready = in_ready;

    ugn_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // item fields are captured on the accepting edge by the datapath
    ugn_datapath #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_CELL_SPAN (MAX_CELL_SPAN)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_kind         (items.kind),
        .in_particle_id  (items.particle_id),
        .in_pos_x        (items.pos_x),
        .in_pos_y        (items.pos_y),
        .in_radius       (items.radius),
        .in_result_limit (items.result_limit),
        .results         (results),
        .cfg             (cfg)
    );

endmodule

// ----- hdl/ugn_datapath.sv -----
// ugn_datapath: config registers, shared multiplier, cell fill and entry memories,
// scan counters, pending hit and output register; depends on ugn_pkg and ugn_ifs
module ugn_datapath #(
    parameter int MAX_COLUMNS   = 64,
    parameter int MAX_ROWS      = 64,
    parameter int CELL_CAPACITY = 8,
    parameter int MAX_CELL_SPAN = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ugn_pkg::cmd_t                    cmd,
    output ugn_pkg::stat_t                   stat,
    input  logic [ugn_pkg::KIND_W-1:0]       in_kind,
    input  logic [ugn_pkg::ID_W-1:0]         in_particle_id,
    input  logic signed [ugn_pkg::POS_W-1:0] in_pos_x,
    input  logic signed [ugn_pkg::POS_W-1:0] in_pos_y,
    input  logic [ugn_pkg::RAD_W-1:0]        in_radius,
    input  logic [ugn_pkg::LIM_W-1:0]        in_result_limit,
    ugn_result_if.source                     results,
    ugn_cfg_if.sink                          cfg
);

    localparam int CW     = $clog2(MAX_COLUMNS);
    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CNW    = $clog2(MAX_COLUMNS + 1);
    localparam int RNW    = $clog2(MAX_ROWS + 1);
    localparam int EWC    = (CNW > ugn_pkg::GRID_W) ? CNW : ugn_pkg::GRID_W;
    localparam int EWR    = (RNW > ugn_pkg::GRID_W) ? RNW : ugn_pkg::GRID_W;
    localparam int SPW    = $clog2(MAX_CELL_SPAN + 1);
    localparam int CSW    = ((CW > SPW) ? CW : SPW) + 2;
    localparam int RSW    = ((RW > SPW) ? RW : SPW) + 2;
    localparam int NCELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int CAW    = $clog2(NCELLS);
    localparam int NENT   = NCELLS * CELL_CAPACITY;
    localparam int EAW    = $clog2(NENT);
    localparam int FW     = $clog2(CELL_CAPACITY + 1);
    localparam logic [ugn_pkg::PROD_W-1:0] CEIL_ADD =
        (ugn_pkg::PROD_W'(1) << ugn_pkg::CELL_SHIFT) - ugn_pkg::PROD_W'(1);

    // configuration
    logic [ugn_pkg::GRID_W-1:0]  cols_cfg_reg, rows_cfg_reg;
    logic [ugn_pkg::SCALE_W-1:0] col_sc_reg, row_sc_reg, span_sc_reg;
    logic [EWC-1:0] cols_ext, cols_eff;
    logic [EWR-1:0] rows_ext, rows_eff;

    // item
    logic [ugn_pkg::KIND_W-1:0]       kind_reg;
    logic [ugn_pkg::ID_W-1:0]         pid_reg;
    logic signed [ugn_pkg::POS_W-1:0] px_reg, py_reg;
    logic [ugn_pkg::RAD_W-1:0]        rad_reg;
    logic [ugn_pkg::LIM_W-1:0]        lim_reg, lim_next;
    logic [ugn_pkg::LIM_W-1:0]        hits_reg;

    // multiplier
    logic signed [ugn_pkg::MUL_W-1:0]  op_a, op_b;
    logic signed [ugn_pkg::PROD_W-1:0] mul_reg;
    ugn_pkg::mul_op_t                  mop_reg;
    logic [ugn_pkg::HI_W-1:0]          prod_hi, span_hi;
    logic [ugn_pkg::PROD_W-1:0]        span_sum;
    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [SPW-1:0] span_reg, span_next;
    logic [ugn_pkg::RSQ_W-1:0] rsq_reg;
    logic [ugn_pkg::SQ_W-1:0]  sqx_reg, sqy_reg;

    // scan
    logic signed [SPW:0] dr_reg, dc_reg, spn;
    logic signed [RSW-1:0] r_s;
    logic signed [CSW-1:0] c_s;
    logic [RW-1:0]  r_u;
    logic [CW-1:0]  c_u;
    logic [CAW-1:0] cell_addr, sweep_reg;
    logic [FW-1:0]  ent_i_reg;

    // memories
    logic [FW-1:0]             fill_mem [NCELLS];
    logic [ugn_pkg::ENT_W-1:0] ent_mem [NENT];
    logic [FW-1:0]             fill_q;
    logic [ugn_pkg::ENT_W-1:0] e_q;
    logic signed [ugn_pkg::POS_W-1:0] ent_x, ent_y;
    logic signed [ugn_pkg::DW-1:0]    dx, dy;
    logic [ugn_pkg::DW-1:0]           ax, ay;

    // pending hit and output
    logic                      pend_valid_reg;
    logic [ugn_pkg::ENT_W-1:0] pend_reg;
    ugn_pkg::status_t          fin_reg;
    logic                      out_valid_reg, out_last_reg, out_load;
    logic [ugn_pkg::ST_W-1:0]  out_st_reg;
    logic [ugn_pkg::ENT_W-1:0] out_ent_reg;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cols_ext = EWC'(cols_cfg_reg);
        rows_ext = EWR'(rows_cfg_reg);
        if (cols_ext < EWC'(2))
            cols_eff = EWC'(2);
        else if (cols_ext > EWC'(MAX_COLUMNS))
            cols_eff = EWC'(MAX_COLUMNS);
        else
            cols_eff = cols_ext;
        if (rows_ext < EWR'(2))
            rows_eff = EWR'(2);
        else if (rows_ext > EWR'(MAX_ROWS))
            rows_eff = EWR'(MAX_ROWS);
        else
            rows_eff = rows_ext;
    end

    always_comb
    begin
        if (in_result_limit == '0)
            lim_next = ugn_pkg::LIM_W'(1);
        else if (in_result_limit > ugn_pkg::LIM_W'(ugn_pkg::MAX_RESULTS))
            lim_next = ugn_pkg::LIM_W'(ugn_pkg::MAX_RESULTS);
        else
            lim_next = in_result_limit;
    end

    // entry fields and distance terms
    assign ent_x = e_q[ugn_pkg::ID_W +: ugn_pkg::POS_W];
    assign ent_y = e_q[ugn_pkg::ID_W + ugn_pkg::POS_W +: ugn_pkg::POS_W];
    assign dx = ugn_pkg::DW'(ent_x) - ugn_pkg::DW'(px_reg);
    assign dy = ugn_pkg::DW'(ent_y) - ugn_pkg::DW'(py_reg);
    assign ax = dx[ugn_pkg::DW-1] ? ugn_pkg::DW'(-dx) : ugn_pkg::DW'(dx);
    assign ay = dy[ugn_pkg::DW-1] ? ugn_pkg::DW'(-dy) : ugn_pkg::DW'(dy);

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul_op)
            ugn_pkg::MOP_COL:
            begin
                op_a = ugn_pkg::MUL_W'(px_reg);
                op_b = ugn_pkg::MUL_W'(col_sc_reg);
            end
            ugn_pkg::MOP_ROW:
            begin
                op_a = ugn_pkg::MUL_W'(py_reg);
                op_b = ugn_pkg::MUL_W'(row_sc_reg);
            end
            ugn_pkg::MOP_SPAN:
            begin
                op_a = ugn_pkg::MUL_W'(rad_reg);
                op_b = ugn_pkg::MUL_W'(span_sc_reg);
            end
            ugn_pkg::MOP_RSQ:
            begin
                op_a = ugn_pkg::MUL_W'(rad_reg);
                op_b = ugn_pkg::MUL_W'(rad_reg);
            end
            ugn_pkg::MOP_DX:
            begin
                op_a = ugn_pkg::MUL_W'(ax);
                op_b = ugn_pkg::MUL_W'(ax);
            end
            ugn_pkg::MOP_DY:
            begin
                op_a = ugn_pkg::MUL_W'(ay);
                op_b = ugn_pkg::MUL_W'(ay);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // cell clamp and span saturation from the product register
    assign prod_hi  = mul_reg[ugn_pkg::PROD_W-1:ugn_pkg::CELL_SHIFT];
    assign span_sum = mul_reg + CEIL_ADD;
    assign span_hi  = span_sum[ugn_pkg::PROD_W-1:ugn_pkg::CELL_SHIFT];

    always_comb
    begin
        if (mul_reg[ugn_pkg::PROD_W-1])
            col_next = '0;
        else if (prod_hi >= ugn_pkg::HI_W'(cols_eff))
            col_next = CW'(cols_eff - EWC'(1));
        else
            col_next = CW'(prod_hi);
        if (mul_reg[ugn_pkg::PROD_W-1])
            row_next = '0;
        else if (prod_hi >= ugn_pkg::HI_W'(rows_eff))
            row_next = RW'(rows_eff - EWR'(1));
        else
            row_next = RW'(prod_hi);
        if (span_hi > ugn_pkg::HI_W'(MAX_CELL_SPAN))
            span_next = SPW'(MAX_CELL_SPAN);
        else
            span_next = SPW'(span_hi);
    end

    // cell under the scan window
    assign spn = $signed({1'b0, span_reg});
    assign r_s = RSW'($signed({1'b0, row_reg})) + RSW'(dr_reg);
    assign c_s = CSW'($signed({1'b0, col_reg})) + CSW'(dc_reg);
    assign r_u = r_s[RW-1:0];
    assign c_u = c_s[CW-1:0];
    assign cell_addr = CAW'(r_u * MAX_COLUMNS + c_u);

    assign out_load = (cmd.hit && pend_valid_reg) || cmd.out_final;

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.cell_ok    = !r_s[RSW-1] && (r_s < RSW'(rows_eff))
                          && !c_s[CSW-1] && (c_s < CSW'(cols_eff));
        stat.last_cell  = (dr_reg == spn) && (dc_reg == spn);
        stat.ent_more   = ent_i_reg < fill_q;
        stat.full       = fill_q >= FW'(CELL_CAPACITY);
        stat.in_range   = (ugn_pkg::SUM_W'(sqx_reg) + ugn_pkg::SUM_W'(sqy_reg))
                          <= ugn_pkg::SUM_W'(rsq_reg);
        stat.limit_next = ugn_pkg::LIM_W'(hits_reg + ugn_pkg::LIM_W'(1)) == lim_reg;
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = !out_valid_reg || results.ready;
        stat.sweep_last = sweep_reg == CAW'(NCELLS - 1);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg   <= ugn_pkg::GRID_W'(2);
            rows_cfg_reg   <= ugn_pkg::GRID_W'(2);
            col_sc_reg     <= ugn_pkg::SCALE_W'(65536);
            row_sc_reg     <= ugn_pkg::SCALE_W'(65536);
            span_sc_reg    <= ugn_pkg::SCALE_W'(65536);
            mop_reg        <= ugn_pkg::MOP_NONE;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    ugn_pkg::CFG_COLUMNS: cols_cfg_reg <= cfg.data[ugn_pkg::GRID_W-1:0];
                    ugn_pkg::CFG_ROWS:    rows_cfg_reg <= cfg.data[ugn_pkg::GRID_W-1:0];
                    ugn_pkg::CFG_COL_SC:  col_sc_reg   <= cfg.data;
                    ugn_pkg::CFG_ROW_SC:  row_sc_reg   <= cfg.data;
                    ugn_pkg::CFG_SPAN_SC: span_sc_reg  <= cfg.data;
                    default: ;
                endcase
            end
            mop_reg <= cmd.mul_op;
            if (cmd.sweep_step)
                sweep_reg <= (sweep_reg == CAW'(NCELLS - 1)) ? '0 : sweep_reg + CAW'(1);
            if (cmd.load_item)
                pend_valid_reg <= 1'b0;
            else if (cmd.hit)
                pend_valid_reg <= 1'b1;
            else if (cmd.out_final)
                pend_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= in_kind;
            pid_reg  <= in_particle_id;
            px_reg   <= in_pos_x;
            py_reg   <= in_pos_y;
            rad_reg  <= in_radius;
            lim_reg  <= lim_next;
            hits_reg <= '0;
        end
        else if (cmd.hit)
            hits_reg <= hits_reg + ugn_pkg::LIM_W'(1);
        mul_reg <= op_a * op_b;
        unique case (mop_reg)
            ugn_pkg::MOP_COL:  col_reg  <= col_next;
            ugn_pkg::MOP_ROW:  row_reg  <= row_next;
            ugn_pkg::MOP_SPAN: span_reg <= span_next;
            ugn_pkg::MOP_RSQ:  rsq_reg  <= mul_reg[ugn_pkg::RSQ_W-1:0];
            ugn_pkg::MOP_DX:   sqx_reg  <= mul_reg[ugn_pkg::SQ_W-1:0];
            ugn_pkg::MOP_DY:   sqy_reg  <= mul_reg[ugn_pkg::SQ_W-1:0];
            default: ;
        endcase
        if (cmd.span_fixed)
            span_reg <= (kind_reg == ugn_pkg::K_NBHD) ? SPW'(1) : '0;
        if (cmd.scan_init)
        begin
            dr_reg <= -spn;
            dc_reg <= -spn;
        end
        else if (cmd.scan_next)
        begin
            if (dc_reg == spn)
            begin
                dc_reg <= -spn;
                dr_reg <= dr_reg + (SPW+1)'(1);
            end
            else
                dc_reg <= dc_reg + (SPW+1)'(1);
        end
        if (cmd.ent_init)
            ent_i_reg <= '0;
        else if (cmd.ent_next)
            ent_i_reg <= ent_i_reg + FW'(1);
        if (cmd.set_fin)
            fin_reg <= cmd.fin_code;
        if (cmd.hit)
            pend_reg <= e_q;
        if (out_load)
        begin
            out_last_reg <= cmd.out_final;
            if (cmd.hit)
            begin
                out_st_reg  <= ugn_pkg::ST_OK;
                out_ent_reg <= pend_reg;
            end
            else if (pend_valid_reg)
            begin
                out_st_reg  <= ugn_pkg::ST_OK;
                out_ent_reg <= pend_reg;
            end
            else
            begin
                out_st_reg  <= fin_reg;
                out_ent_reg <= '0;
            end
        end
    end

    // cell fill memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step)
            fill_mem[sweep_reg] <= '0;
        else if (cmd.ins_write)
            fill_mem[cell_addr] <= FW'(fill_q + FW'(1));
        if (cmd.fill_rd)
            fill_q <= fill_mem[cell_addr];
    end

    // cell entry memory
    always_ff @(posedge clk)
    begin
        if (cmd.ins_write)
            ent_mem[EAW'(cell_addr * CELL_CAPACITY + fill_q)] <=
                {py_reg, px_reg, pid_reg};
        if (cmd.ent_rd)
            e_q <= ent_mem[EAW'(cell_addr * CELL_CAPACITY + ent_i_reg)];
    end

    assign results.valid    = out_valid_reg;
    assign results.status   = out_st_reg;
    assign results.found_id = out_ent_reg[ugn_pkg::ID_W-1:0];
    assign results.found_x  = out_ent_reg[ugn_pkg::ID_W +: ugn_pkg::POS_W];
    assign results.found_y  = out_ent_reg[ugn_pkg::ID_W + ugn_pkg::POS_W +: ugn_pkg::POS_W];
    assign results.last     = out_last_reg;

endmodule

// ----- hdl/ugn_controller.sv -----
// ugn_controller: one-hot sequencer for insert, clear and query items
// depends on ugn_pkg
module ugn_controller (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ugn_pkg::stat_t stat,
    output ugn_pkg::cmd_t  cmd
);

    typedef enum logic [19:0] {
        S_RSTCLR = 20'b1 << 0,
        S_IDLE   = 20'b1 << 1,
        S_DISP   = 20'b1 << 2,
        S_CLR    = 20'b1 << 3,
        S_MCOL   = 20'b1 << 4,
        S_MROW   = 20'b1 << 5,
        S_MSPAN  = 20'b1 << 6,
        S_MRSQ   = 20'b1 << 7,
        S_INIT   = 20'b1 << 8,
        S_IRD    = 20'b1 << 9,
        S_ICHK   = 20'b1 << 10,
        S_CELL   = 20'b1 << 11,
        S_FILLW  = 20'b1 << 12,
        S_ENT    = 20'b1 << 13,
        S_ENTW   = 20'b1 << 14,
        S_MDY    = 20'b1 << 15,
        S_CMPW   = 20'b1 << 16,
        S_CMP    = 20'b1 << 17,
        S_HIT    = 20'b1 << 18,
        S_FIN    = 20'b1 << 19
    } state_t;

    state_t state_reg, state_next;
    logic   is_radius, is_insert;

    assign is_radius = stat.kind == ugn_pkg::K_RADIUS;
    assign is_insert = stat.kind == ugn_pkg::K_INSERT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_RSTCLR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_RSTCLR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.kind) inside
                    ugn_pkg::K_CLEAR: state_next = S_CLR;
                    ugn_pkg::K_INSERT, ugn_pkg::K_CELL, ugn_pkg::K_NBHD, ugn_pkg::K_RADIUS:
                        state_next = S_MCOL;
                    default: state_next = S_IDLE;
                endcase
            end
            S_CLR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.set_fin  = 1'b1;
                    cmd.fin_code = ugn_pkg::ST_OK;
                    state_next   = S_FIN;
                end
            end
            S_MCOL:
            begin
                cmd.mul_op = ugn_pkg::MOP_COL;
                state_next = S_MROW;
            end
            S_MROW:
            begin
                cmd.mul_op = ugn_pkg::MOP_ROW;
                state_next = S_MSPAN;
            end
            S_MSPAN:
            begin
                if (is_radius)
                    cmd.mul_op = ugn_pkg::MOP_SPAN;
                else
                    cmd.span_fixed = 1'b1;
                state_next = S_MRSQ;
            end
            S_MRSQ:
            begin
                if (is_radius)
                    cmd.mul_op = ugn_pkg::MOP_RSQ;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.scan_init = 1'b1;
                cmd.set_fin   = 1'b1;
                cmd.fin_code  = ugn_pkg::ST_NONE;
                state_next    = is_insert ? S_IRD : S_CELL;
            end
            S_IRD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_ICHK;
            end
            S_ICHK:
            begin
                cmd.set_fin   = 1'b1;
                cmd.fin_code  = stat.full ? ugn_pkg::ST_FULL : ugn_pkg::ST_OK;
                cmd.ins_write = !stat.full;
                state_next    = S_FIN;
            end
            S_CELL:
            begin
                if (stat.cell_ok)
                begin
                    cmd.fill_rd = 1'b1;
                    state_next  = S_FILLW;
                end
                else if (stat.last_cell)
                    state_next = S_FIN;
                else
                    cmd.scan_next = 1'b1;
            end
            S_FILLW:
            begin
                cmd.ent_init = 1'b1;
                state_next   = S_ENT;
            end
            S_ENT:
            begin
                if (stat.ent_more)
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_ENTW;
                end
                else if (stat.last_cell)
                    state_next = S_FIN;
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_CELL;
                end
            end
            S_ENTW:
            begin
                if (is_radius)
                begin
                    cmd.mul_op = ugn_pkg::MOP_DX;
                    state_next = S_MDY;
                end
                else
                    state_next = S_HIT;
            end
            S_MDY:
            begin
                cmd.mul_op = ugn_pkg::MOP_DY;
                state_next = S_CMPW;
            end
            S_CMPW:
                state_next = S_CMP;
            S_CMP:
            begin
                if (stat.in_range)
                    state_next = S_HIT;
                else
                begin
                    cmd.ent_next = 1'b1;
                    state_next   = S_ENT;
                end
            end
            S_HIT:
            begin
                if (!stat.pend_valid || stat.out_free)
                begin
                    cmd.hit      = 1'b1;
                    cmd.ent_next = 1'b1;
                    state_next   = stat.limit_next ? S_FIN : S_ENT;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_final = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- hdl/ugn_checker.sv -----
// ugn_checker: port-level assertions for the neighbor engine, bound to the top level
// depends on ugn_pkg
module ugn_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [ugn_pkg::KIND_W-1:0]   in_kind,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ugn_pkg::ST_W-1:0]     out_status,
    input logic [ugn_pkg::ID_W-1:0]     out_id,
    input logic [ugn_pkg::POS_W-1:0]    out_x,
    input logic [ugn_pkg::POS_W-1:0]    out_y,
    input logic                         out_last
);

    // items accepted whose last word is not yet taken
    logic [1:0] open_reg;
    logic       inc, dec;

    assign inc = in_valid && in_ready && (in_kind <= ugn_pkg::K_RADIUS);
    assign dec = out_valid && out_ready && out_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else
            open_reg <= open_reg + 2'(inc) - 2'(dec);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_last))
        else $error("result word changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 2'd0)
        else $error("result word without an open item");

    a_idle_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> open_reg <= 2'd1)
        else $error("item taken with more than one item still open");

    a_mid_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != ugn_pkg::ST_OK)
        |-> out_last && out_id == '0 && out_x == '0 && out_y == '0)
        else $error("non-hit word not final or not zeroed");

endmodule

bind uniform_grid_neighbor_engine_top ugn_checker u_ugn_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .in_kind    (items.kind),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_status (results.status),
    .out_id     (results.found_id),
    .out_x      (results.found_x),
    .out_y      (results.found_y),
    .out_last   (results.last)
);
